FILE: rtl/ucw_pkg.sv
`default_nettype none

package ucw_pkg;

	// field widths
	localparam int BYTE_W = 8;
	localparam int CP_W = 21;
	localparam int SUM_W = 20;
	localparam int COL_W = 5;

	// default tab stop width
	localparam int TAB_COLUMNS_DEF = 8;

	// event queue between decoder and accumulator
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// byte and code point constants
	localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ESC = 8'h1B;
	localparam logic [BYTE_W-1:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] BYTE_SGR_END = 8'h6D;
	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_ZWJ = 21'h00200D;
	localparam logic [CP_W-1:0] CP_VS_LO = 21'h00FE00;
	localparam logic [CP_W-1:0] CP_VS_HI = 21'h00FE0F;
	localparam logic [CP_W-1:0] CP_TAB = 21'h000009;
	localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
	localparam logic [CP_W-1:0] CP_DEL = 21'h00007F;
	localparam logic [CP_W-1:0] CP_C1_LO = 21'h000080;

	// double width ranges
	localparam int WIDE_COUNT = 23;
	localparam logic [CP_W-1:0] WIDE_LO [WIDE_COUNT] = '{
		21'h04E00, 21'h03400, 21'h20000, 21'h2A700, 21'h2B740, 21'h2B820, 21'h0F900,
		21'h2F800, 21'h0FF01, 21'h0FFE0, 21'h0AC00, 21'h03040, 21'h030A0, 21'h01100,
		21'h02E80, 21'h02F00, 21'h03000, 21'h03200, 21'h03300, 21'h1F300, 21'h1F600,
		21'h02600, 21'h1FA00
	};
	localparam logic [CP_W-1:0] WIDE_HI [WIDE_COUNT] = '{
		21'h09FFF, 21'h04DBF, 21'h2A6DF, 21'h2B73F, 21'h2B81F, 21'h2CEAF, 21'h0FAFF,
		21'h2FA1F, 21'h0FF60, 21'h0FFE6, 21'h0D7A3, 21'h0309F, 21'h030FF, 21'h0115F,
		21'h02EFF, 21'h02FDF, 21'h0303F, 21'h032FF, 21'h033FF, 21'h1F9FF, 21'h1F6FF,
		21'h027BF, 21'h1FA6F
	};

	typedef enum logic [1:0] {
		WCLS_ZERO,
		WCLS_ONE,
		WCLS_TWO,
		WCLS_TAB
	} width_class_t;

	// one decoded event from the front end
	typedef struct packed {
		logic cp_valid;
		logic [CP_W-1:0] cp;
		logic last;
		logic cut;
	} ucw_event_t;

	// column class of one code point
	function automatic width_class_t cp_class(input logic [CP_W-1:0] cp);
		logic wide;
		width_class_t cls;
		wide = 1'b0;
		for (int i = 0; i < WIDE_COUNT; i++) begin
			if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
				wide = 1'b1;
			end
		end
		if (cp == CP_ZWJ || (cp >= CP_VS_LO && cp <= CP_VS_HI)) begin
			cls = WCLS_ZERO;
		end else if (wide) begin
			cls = WCLS_TWO;
		end else if (cp >= CP_SPACE && cp < CP_DEL) begin
			cls = WCLS_ONE;
		end else if (cp == CP_TAB) begin
			cls = WCLS_TAB;
		end else if (cp >= CP_C1_LO) begin
			cls = WCLS_ONE;
		end else begin
			cls = WCLS_ZERO;
		end
		return cls;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ucw_if.sv
`default_nettype none

// byte stream channel
interface ucw_byte_if;
	logic valid;
	logic ready;
	logic [ucw_pkg::BYTE_W-1:0] data_byte;
	logic last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// width result channel
interface ucw_result_if;
	logic valid;
	logic ready;
	logic [ucw_pkg::SUM_W-1:0] display_width;
	logic cut_off;

	modport source (output valid, output display_width, output cut_off, input ready);
	modport sink (input valid, input display_width, input cut_off, output ready);
endinterface

`default_nettype wire

FILE: rtl/ucw_front.sv
`default_nettype none

module ucw_front (
	input wire logic clk,
	input wire logic arst_n,
	ucw_byte_if.sink text,
	output logic push_valid,
	input wire logic push_ready,
	output ucw_pkg::ucw_event_t push_data
);

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_AFTER_ESC,
		MODE_IN_ESCAPE,
		MODE_IN_SEQ,
		MODE_DONE
	} mode_t;

	mode_t mode_q, mode_d;
	logic [1:0] rem_q, rem_d;
	logic [ucw_pkg::CP_W-1:0] part_q, part_d;

	logic [ucw_pkg::BYTE_W-1:0] b;
	logic accept;
	logic [ucw_pkg::CP_W-1:0] seq_cp;

	// lead byte decode
	mode_t lead_mode;
	logic [1:0] lead_rem;
	logic [ucw_pkg::CP_W-1:0] lead_part;
	logic lead_cp_valid;
	logic [ucw_pkg::CP_W-1:0] lead_cp;

	logic ev_cp_valid;
	logic [ucw_pkg::CP_W-1:0] ev_cp;

	assign b = text.data_byte;
	assign text.ready = push_ready;
	assign accept = text.valid && push_ready;
	assign seq_cp = {part_q[ucw_pkg::CP_W-7:0], b[5:0]};

	// classify a byte in lead position
	always_comb begin
		lead_mode = MODE_NORMAL;
		lead_rem = 2'd0;
		lead_part = '0;
		lead_cp_valid = 1'b0;
		lead_cp = '0;
		if (b == ucw_pkg::BYTE_NUL) begin
			lead_mode = MODE_DONE;
		end else if (b == ucw_pkg::BYTE_ESC) begin
			lead_mode = MODE_AFTER_ESC;
		end else if (!b[7]) begin
			lead_cp_valid = 1'b1;
			lead_cp = {{(ucw_pkg::CP_W-ucw_pkg::BYTE_W){1'b0}}, b};
		end else if (b[7:5] == 3'b110) begin
			lead_mode = MODE_IN_SEQ;
			lead_rem = 2'd1;
			lead_part = {{(ucw_pkg::CP_W-5){1'b0}}, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			lead_mode = MODE_IN_SEQ;
			lead_rem = 2'd2;
			lead_part = {{(ucw_pkg::CP_W-4){1'b0}}, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			lead_mode = MODE_IN_SEQ;
			lead_rem = 2'd3;
			lead_part = {{(ucw_pkg::CP_W-3){1'b0}}, b[2:0]};
		end else begin
			lead_cp_valid = 1'b1;
			lead_cp = ucw_pkg::CP_REPLACEMENT;
		end
	end

	// scanner next state and emitted code point
	always_comb begin
		mode_d = mode_q;
		rem_d = rem_q;
		part_d = part_q;
		ev_cp_valid = 1'b0;
		ev_cp = '0;
		unique case (mode_q)
			MODE_NORMAL: begin
				mode_d = lead_mode;
				rem_d = (lead_mode == MODE_IN_SEQ) ? lead_rem : rem_q;
				part_d = (lead_mode == MODE_IN_SEQ) ? lead_part : part_q;
				ev_cp_valid = lead_cp_valid;
				ev_cp = lead_cp;
			end
			MODE_AFTER_ESC: begin
				// a lone escape is zero columns wide, so only the new lead counts
				if (b == ucw_pkg::BYTE_LBRACKET) begin
					mode_d = MODE_IN_ESCAPE;
				end else begin
					mode_d = lead_mode;
					rem_d = (lead_mode == MODE_IN_SEQ) ? lead_rem : rem_q;
					part_d = (lead_mode == MODE_IN_SEQ) ? lead_part : part_q;
					ev_cp_valid = lead_cp_valid;
					ev_cp = lead_cp;
				end
			end
			MODE_IN_ESCAPE: begin
				if (b == ucw_pkg::BYTE_NUL) begin
					mode_d = MODE_DONE;
				end else if (b == ucw_pkg::BYTE_SGR_END) begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_IN_SEQ: begin
				rem_d = rem_q - 2'd1;
				if (rem_q == 2'd1) begin
					ev_cp_valid = 1'b1;
					ev_cp = seq_cp;
					part_d = '0;
					mode_d = MODE_NORMAL;
				end else begin
					part_d = seq_cp;
				end
			end
			MODE_DONE: begin
				mode_d = MODE_DONE;
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
	end

	// event toward the queue
	always_comb begin
		push_data.cp_valid = ev_cp_valid;
		push_data.cp = ev_cp;
		push_data.last = text.last;
		push_data.cut = (mode_d == MODE_IN_SEQ) || (mode_d == MODE_IN_ESCAPE);
		push_valid = accept && (ev_cp_valid || text.last);
	end

	// scanner state, cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			rem_q <= 2'd0;
			part_q <= '0;
		end else if (accept) begin
			if (text.last) begin
				mode_q <= MODE_NORMAL;
				rem_q <= 2'd0;
				part_q <= '0;
			end else begin
				mode_q <= mode_d;
				rem_q <= rem_d;
				part_q <= part_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ucw_fifo.sv
`default_nettype none

module ucw_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire ucw_pkg::ucw_event_t push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output ucw_pkg::ucw_event_t pop_data
);

	ucw_pkg::ucw_event_t entry_q [ucw_pkg::FIFO_DEPTH];
	logic [ucw_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [ucw_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [ucw_pkg::FIFO_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != ucw_pkg::FIFO_CNT_W'(ucw_pkg::FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ucw_back.sv
`default_nettype none

module ucw_back #(
	parameter int TAB_COLUMNS = ucw_pkg::TAB_COLUMNS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire ucw_pkg::ucw_event_t pop_data,
	ucw_result_if.source result
);

	logic valid_s1;
	logic last_s1;
	logic cut_s1;
	logic [ucw_pkg::COL_W-1:0] cols_s1;

	logic [ucw_pkg::SUM_W-1:0] sum_q;
	logic out_valid_q;
	logic [ucw_pkg::SUM_W-1:0] out_width_q;
	logic out_cut_q;

	ucw_pkg::width_class_t cls;
	logic [ucw_pkg::COL_W-1:0] cols;
	logic s1_free;
	logic s1_take;
	logic [ucw_pkg::SUM_W:0] sum_raw;
	logic [ucw_pkg::SUM_W-1:0] sum_sat;

	// width lookup of the incoming code point
	always_comb begin
		cls = ucw_pkg::cp_class(pop_data.cp);
		cols = '0;
		if (pop_data.cp_valid) begin
			unique case (cls)
				ucw_pkg::WCLS_ZERO: cols = '0;
				ucw_pkg::WCLS_ONE: cols = ucw_pkg::COL_W'(1);
				ucw_pkg::WCLS_TWO: cols = ucw_pkg::COL_W'(2);
				ucw_pkg::WCLS_TAB: cols = ucw_pkg::COL_W'(TAB_COLUMNS);
				default: cols = '0;
			endcase
		end
	end

	// stage 1 moves on unless it holds a final beat the output cannot take
	assign s1_take = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign s1_free = !valid_s1 || s1_take;
	assign pop_ready = s1_free;

	// saturating accumulate
	assign sum_raw = {1'b0, sum_q} + {{(ucw_pkg::SUM_W+1-ucw_pkg::COL_W){1'b0}}, cols_s1};
	assign sum_sat = sum_raw[ucw_pkg::SUM_W] ? '1 : sum_raw[ucw_pkg::SUM_W-1:0];

	// width stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pop_valid) begin
			last_s1 <= pop_data.last;
			cut_s1 <= pop_data.cut;
			cols_s1 <= cols;
		end
	end

	// running sum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_take) begin
				if (last_s1) begin
					sum_q <= '0;
					out_valid_q <= 1'b1;
				end else begin
					sum_q <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && last_s1) begin
			out_width_q <= sum_sat;
			out_cut_q <= cut_s1;
		end
	end

	assign result.valid = out_valid_q;
	assign result.display_width = out_width_q;
	assign result.cut_off = out_cut_q;

endmodule

`default_nettype wire

FILE: rtl/utf8_display_width_counter_core.sv
`default_nettype none

// channel   dir  beat fields                  handshake
// text      in   data_byte[7:0], last          valid/ready
// result    out  display_width[19:0], cut_off  valid/ready
//
// One byte is taken every cycle while the queue has room; the decoder works on each
// byte in the cycle it is accepted and pushes at most one code point event into a
// 4-entry queue. The final byte then passes through the queue, the width lookup stage
// and the result register, in that order, before its result is valid.
// Reset clears the scanner, queue, pipeline valid and running sum.
// A result held on the output stalls only a final-byte event; later events wait in the queue.

module utf8_display_width_counter_core #(
	parameter int TAB_COLUMNS = ucw_pkg::TAB_COLUMNS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ucw_byte_if.sink text,
	ucw_result_if.source result
);

	logic push_valid;
	logic push_ready;
	ucw_pkg::ucw_event_t push_data;
	logic pop_valid;
	logic pop_ready;
	ucw_pkg::ucw_event_t pop_data;

	// byte decoder
	ucw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	// event queue
	ucw_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	// width lookup and accumulator
	ucw_back #(
		.TAB_COLUMNS(TAB_COLUMNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.result(result)
	);

endmodule

`default_nettype wire

FILE: sim/tb_utf8_display_width_counter_core.sv
module tb_utf8_display_width_counter_core;

	localparam int TAB_COLS = 8;
	localparam int unsigned SUM_MAX = 32'h000F_FFFF;
	localparam int RANDOM_BEATS = 1400;

	// byte values and code points the scanner reacts to
	localparam logic [7:0] NUL_B = 8'h00;
	localparam logic [7:0] TAB_B = 8'h09;
	localparam logic [7:0] ESC_B = 8'h1B;
	localparam logic [7:0] LBRACKET_B = 8'h5B;
	localparam logic [7:0] SGR_END_B = 8'h6D;
	localparam logic [20:0] CP_ESC = 21'h00001B;
	localparam logic [20:0] CP_FFFD = 21'h00FFFD;
	localparam logic [20:0] CP_JOINER = 21'h00200D;
	localparam logic [20:0] CP_VSEL_LO = 21'h00FE00;
	localparam logic [20:0] CP_VSEL_HI = 21'h00FE0F;

	// double column ranges
	localparam int DOUBLE_N = 23;
	localparam logic [20:0] DOUBLE_LO [DOUBLE_N] = '{
		21'h04E00, 21'h03400, 21'h20000, 21'h2A700, 21'h2B740, 21'h2B820, 21'h0F900,
		21'h2F800, 21'h0FF01, 21'h0FFE0, 21'h0AC00, 21'h03040, 21'h030A0, 21'h01100,
		21'h02E80, 21'h02F00, 21'h03000, 21'h03200, 21'h03300, 21'h1F300, 21'h1F600,
		21'h02600, 21'h1FA00
	};
	localparam logic [20:0] DOUBLE_HI [DOUBLE_N] = '{
		21'h09FFF, 21'h04DBF, 21'h2A6DF, 21'h2B73F, 21'h2B81F, 21'h2CEAF, 21'h0FAFF,
		21'h2FA1F, 21'h0FF60, 21'h0FFE6, 21'h0D7A3, 21'h0309F, 21'h030FF, 21'h0115F,
		21'h02EFF, 21'h02FDF, 21'h0303F, 21'h032FF, 21'h033FF, 21'h1F9FF, 21'h1F6FF,
		21'h027BF, 21'h1FA6F
	};

	// code points on the edges of the width classes and encodings
	localparam int EDGE_N = 26;
	localparam logic [20:0] EDGE_CPS [EDGE_N] = '{
		21'h00000, 21'h00008, 21'h00009, 21'h0000A, 21'h0001F, 21'h00020, 21'h0007E,
		21'h0007F, 21'h00080, 21'h0009F, 21'h000A0, 21'h007FF, 21'h00800, 21'h0200C,
		21'h0200D, 21'h0200E, 21'h0FDFF, 21'h0FE00, 21'h0FE0F, 21'h0FE10, 21'h0FFFD,
		21'h0FFFF, 21'h10000, 21'h10FFFF, 21'h110000, 21'h1FFFFF
	};

	typedef enum logic [2:0] {
		SCAN_LEAD,
		SCAN_AFTER_ESC,
		SCAN_CSI,
		SCAN_CONT,
		SCAN_STOPPED
	} scan_state_t;

	typedef struct packed {
		logic [19:0] cols;
		logic cut;
	} string_total_t;

	typedef struct packed {
		logic [7:0] code;
		logic fin;
		logic typed;
		logic [19:0] cols;
		logic cut;
	} text_row_t;

	// directed strings; typed totals where they are obvious
	text_row_t directed_rows [26] = '{
		'{8'h41, 1'b1, 1'b1, 20'd1, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 20'd1, 1'b0},
		'{8'h09, 1'b1, 1'b1, 20'd8, 1'b0},
		'{8'h00, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'hC0, 1'b1, 1'b1, 20'd0, 1'b0},
		'{8'hE4, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'hB8, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h80, 1'b1, 1'b0, 20'd0, 1'b0},
		'{8'hF0, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h9F, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h98, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h80, 1'b1, 1'b0, 20'd0, 1'b0},
		'{8'hC2, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 20'd0, 1'b0},
		'{8'hE4, 1'b1, 1'b1, 20'd0, 1'b1},
		'{8'h1B, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h5B, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h6D, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h1B, 1'b1, 1'b1, 20'd0, 1'b0},
		'{8'h1B, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h41, 1'b1, 1'b1, 20'd1, 1'b0},
		'{8'h1B, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h5B, 1'b1, 1'b1, 20'd0, 1'b1},
		'{8'h1B, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h5B, 1'b0, 1'b0, 20'd0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 20'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	ucw_byte_if text_ch();
	ucw_result_if result_ch();

	utf8_display_width_counter_core #(
		.TAB_COLUMNS(TAB_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.result(result_ch)
	);

	// predictor state
	scan_state_t scan_st;
	logic [1:0] seq_left;
	logic [20:0] cp_acc;
	logic [19:0] col_sum;

	string_total_t due_totals [$];
	logic [7:0] text_buf [$];
	bit sender_burst;
	int fail_count;
	int strings_sent;
	int text_beats;
	int totals_checked;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// columns of one code point
	function automatic int unsigned cols_of(input logic [20:0] cp);
		if (cp == CP_JOINER || (cp >= CP_VSEL_LO && cp <= CP_VSEL_HI)) begin
			return 0;
		end
		for (int i = 0; i < DOUBLE_N; i++) begin
			if (cp >= DOUBLE_LO[i] && cp <= DOUBLE_HI[i]) begin
				return 2;
			end
		end
		if (cp >= 21'h20 && cp < 21'h7F) begin
			return 1;
		end
		if (cp == 21'h09) begin
			return TAB_COLS;
		end
		if (cp >= 21'h80) begin
			return 1;
		end
		return 0;
	endfunction

	task automatic clear_scan();
		scan_st = SCAN_LEAD;
		seq_left = 2'd0;
		cp_acc = '0;
		col_sum = '0;
	endtask

	// saturating running sum
	task automatic add_columns(input int unsigned w);
		int unsigned s;
		s = col_sum + w;
		col_sum = (s > SUM_MAX) ? SUM_MAX[19:0] : s[19:0];
	endtask

	task automatic take_lead_byte(input logic [7:0] b);
		if (b == NUL_B) begin
			scan_st = SCAN_STOPPED;
		end else if (b == ESC_B) begin
			scan_st = SCAN_AFTER_ESC;
		end else if (!b[7]) begin
			add_columns(cols_of({13'd0, b}));
		end else if (b[7:5] == 3'b110) begin
			cp_acc = {16'd0, b[4:0]};
			seq_left = 2'd1;
			scan_st = SCAN_CONT;
		end else if (b[7:4] == 4'b1110) begin
			cp_acc = {17'd0, b[3:0]};
			seq_left = 2'd2;
			scan_st = SCAN_CONT;
		end else if (b[7:3] == 5'b11110) begin
			cp_acc = {18'd0, b[2:0]};
			seq_left = 2'd3;
			scan_st = SCAN_CONT;
		end else begin
			add_columns(cols_of(CP_FFFD));
		end
	endtask

	// advance the scanner by one accepted byte, report the total on the final one
	task automatic scan_text_byte(input logic [7:0] b, input logic fin, output logic got,
			output string_total_t total);
		case (scan_st)
			SCAN_LEAD: begin
				take_lead_byte(b);
			end
			SCAN_AFTER_ESC: begin
				if (b == LBRACKET_B) begin
					scan_st = SCAN_CSI;
				end else begin
					add_columns(cols_of(CP_ESC));
					scan_st = SCAN_LEAD;
					take_lead_byte(b);
				end
			end
			SCAN_CSI: begin
				if (b == NUL_B) begin
					scan_st = SCAN_STOPPED;
				end else if (b == SGR_END_B) begin
					scan_st = SCAN_LEAD;
				end
			end
			SCAN_CONT: begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				seq_left = seq_left - 2'd1;
				if (seq_left == 2'd0) begin
					add_columns(cols_of(cp_acc));
					cp_acc = '0;
					scan_st = SCAN_LEAD;
				end
			end
			default: begin
			end
		endcase
		got = fin;
		total.cols = col_sum;
		total.cut = (scan_st == SCAN_CONT) || (scan_st == SCAN_CSI);
		if (fin) begin
			clear_scan();
		end
	endtask

	task automatic flag_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch: %s expected %0d got %0d", what, want, got);
		end
	endtask

	// drive one text beat and record what it should produce
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input logic [19:0] typed_cols, input logic typed_cut);
		int gap;
		logic got;
		string_total_t total;
		gap = sender_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data_byte <= b;
		text_ch.last <= fin;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		text_beats++;
		scan_text_byte(b, fin, got, total);
		if (got) begin
			if (typed) begin
				total.cols = typed_cols;
				total.cut = typed_cut;
			end
			due_totals.push_back(total);
			strings_sent++;
		end
	endtask

	function automatic logic [20:0] pick_codepoint();
		int k;
		logic [20:0] lo;
		logic [20:0] hi;
		k = $urandom_range(0, DOUBLE_N - 1);
		lo = DOUBLE_LO[k];
		hi = DOUBLE_HI[k];
		case ($urandom_range(0, 4))
			0, 1: begin
				case ($urandom_range(0, 4))
					0: return lo - 21'd1;
					1: return lo;
					2: return hi;
					3: return hi + 21'd1;
					default: return lo + $urandom_range(0, hi - lo);
				endcase
			end
			2: return EDGE_CPS[$urandom_range(0, EDGE_N - 1)];
			3: return $urandom_range(0, 21'h1FFFFF);
			default: return $urandom_range(21'h80, 21'hFFFF);
		endcase
	endfunction

	// utf-8 encode, overlong now and then for ascii; short drops trailing bytes
	task automatic push_cp(input logic [20:0] cp, input bit short);
		int n;
		int keep;
		logic [1:0] top;
		if (cp < 21'h80) begin
			n = ($urandom_range(0, 3) == 0) ? 2 : 1;
		end else if (cp < 21'h800) begin
			n = 2;
		end else if (cp < 21'h10000) begin
			n = 3;
		end else begin
			n = 4;
		end
		case (n)
			1: text_buf.push_back(cp[7:0]);
			2: text_buf.push_back({3'b110, cp[10:6]});
			3: text_buf.push_back({4'b1110, cp[15:12]});
			default: text_buf.push_back({5'b11110, cp[20:18]});
		endcase
		keep = (short && n > 1) ? $urandom_range(0, n - 2) : n - 1;
		for (int i = n - 2; i >= n - 1 - keep; i--) begin
			// continuation bits are taken blindly, so vary the top pair now and then
			top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
			text_buf.push_back({top, cp[6*i +: 6]});
		end
	endtask

	// one random string, mostly well formed
	task automatic build_random_text();
		int parts;
		int pick;
		int k;
		logic [7:0] rb;
		logic [20:0] cp;
		text_buf.delete();
		sender_burst = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0) begin
			parts = $urandom_range(1, 10);
			repeat (parts) begin
				rb = $urandom_range(0, 255);
				text_buf.push_back(rb);
			end
			return;
		end
		parts = $urandom_range(1, 8);
		repeat (parts) begin
			pick = $urandom_range(0, 99);
			if (pick < 28) begin
				rb = $urandom_range(8'h20, 8'h7E);
				text_buf.push_back(rb);
			end else if (pick < 33) begin
				rb = ($urandom_range(0, 4) == 0) ? 8'h7F : 8'($urandom_range(1, 31));
				text_buf.push_back(rb);
			end else if (pick < 36) begin
				text_buf.push_back(TAB_B);
			end else if (pick < 62) begin
				push_cp(pick_codepoint(), 1'b0);
			end else if (pick < 70) begin
				// escape with a few parameter bytes
				text_buf.push_back(ESC_B);
				text_buf.push_back(LBRACKET_B);
				k = $urandom_range(0, 4);
				repeat (k) begin
					if ($urandom_range(0, 5) == 0) begin
						do rb = $urandom_range(1, 255); while (rb == SGR_END_B);
					end else begin
						rb = ($urandom_range(0, 4) == 0) ? 8'h3B : 8'($urandom_range(8'h30, 8'h39));
					end
					text_buf.push_back(rb);
				end
				text_buf.push_back(SGR_END_B);
			end else if (pick < 74) begin
				text_buf.push_back(ESC_B);
				rb = $urandom_range(8'h20, 8'h7E);
				text_buf.push_back(rb);
			end else if (pick < 78) begin
				rb = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
						: 8'($urandom_range(8'hF8, 8'hFF));
				text_buf.push_back(rb);
			end else if (pick < 82) begin
				rb = $urandom_range(1, 255);
				text_buf.push_back(rb);
			end else if (pick < 84) begin
				text_buf.push_back(NUL_B);
			end else if (pick < 88) begin
				push_cp(pick_codepoint(), 1'b1);
			end else begin
				k = $urandom_range(0, DOUBLE_N - 1);
				cp = DOUBLE_LO[k] + $urandom_range(0, DOUBLE_HI[k] - DOUBLE_LO[k]);
				push_cp(cp, 1'b0);
			end
		end
		// sometimes leave a sequence or an escape open at the end
		case ($urandom_range(0, 11))
			0: push_cp($urandom_range(21'h80, 21'h1FFFFF), 1'b1);
			1: begin
				text_buf.push_back(ESC_B);
				text_buf.push_back(LBRACKET_B);
				if ($urandom_range(0, 1)) begin
					text_buf.push_back(8'h31);
				end
			end
			2: text_buf.push_back(ESC_B);
			default: begin
			end
		endcase
	endtask

	// result side: random stalls, compare each beat with the oldest total
	initial begin
		int stall;
		string_total_t want;
		result_ch.ready = 1'b0;
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			if (due_totals.size() == 0) begin
				flag_mismatch("result beat with nothing pending, width", 0,
						result_ch.display_width);
			end else begin
				want = due_totals.pop_front();
				totals_checked++;
				if (result_ch.display_width !== want.cols) begin
					flag_mismatch("display_width", want.cols, result_ch.display_width);
				end
				if (result_ch.cut_off !== want.cut) begin
					flag_mismatch("cut_off", want.cut, result_ch.cut_off);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int random_beats;
		text_ch.valid = 1'b0;
		text_ch.data_byte = '0;
		text_ch.last = 1'b0;
		arst_n = 1'b0;
		fail_count = 0;
		strings_sent = 0;
		text_beats = 0;
		totals_checked = 0;
		random_beats = 0;
		sender_burst = 1'b0;
		clear_scan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].code, directed_rows[i].fin, directed_rows[i].typed,
					directed_rows[i].cols, directed_rows[i].cut);
		end

		// random strings
		while (random_beats < RANDOM_BEATS) begin
			build_random_text();
			for (int i = 0; i < text_buf.size(); i++) begin
				send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0, 1'b0);
			end
			random_beats += text_buf.size();
		end
		text_ch.valid <= 1'b0;

		while (due_totals.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d strings in %0d text beats, %0d totals compared", strings_sent,
				text_beats, totals_checked);
		$display("directed edge cases and %0d random beats under stalls; %0d errors",
				random_beats, fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

endmodule
